// ===== rtl/pgf_pkg.sv =====
// shared types, constants and coefficient tables of the polynomial-gaussian evaluator
package pgf_pkg;

    localparam int COEFF_COUNT_DEF   = 11;
    localparam int FRAC_BITS_OUT_DEF = 20;

    localparam int RADIUS_W = 16;
    localparam int CMD_W    = 2;
    localparam int EXP_W    = 20;
    localparam int VALUE_W  = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_CENTRAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TENSOR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPINISO = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPINISO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    localparam logic [EXP_W-1:0] CENTRAL_EXP_RST = 20'd253722;
    localparam logic [EXP_W-1:0] TENSOR_EXP_RST  = 20'd125762;
    localparam logic [EXP_W-1:0] SPINISO_EXP_RST = 20'd322734;

    // polynomial accumulator, q.24, kept below 2^59 in magnitude
    localparam int ACC_W  = 60;
    localparam int MAG_W  = 59;
    localparam int COEF_W = 40;

    // exponential unit
    localparam int TAYLOR_TERMS = 12;
    localparam int GAUSS_LAT    = 5 + 2 * TAYLOR_TERMS + 1;
    localparam int E_W          = 33;
    localparam longint unsigned ONE_Q32  = 64'd4294967296;
    localparam longint unsigned LN2_Q32  = 64'd2977044472;
    localparam longint unsigned UF_LIMIT = 33 * LN2_Q32;
    localparam longint unsigned K_RECIP  = (64'd1 << 58) / LN2_Q32;

    localparam logic [31:0] RECIP [0:TAYLOR_TERMS] = '{
        32'd0, 32'd0,
        32'(ONE_Q32 / 2), 32'(ONE_Q32 / 3), 32'(ONE_Q32 / 4), 32'(ONE_Q32 / 5),
        32'(ONE_Q32 / 6), 32'(ONE_Q32 / 7), 32'(ONE_Q32 / 8), 32'(ONE_Q32 / 9),
        32'(ONE_Q32 / 10), 32'(ONE_Q32 / 11), 32'(ONE_Q32 / 12)
    };

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [CMD_W-1:0]    command;
    } pgf_request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
    } pgf_result_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic                    huge;
        logic                    huge_neg;
    } pgf_poly_t;

    // nano-unit coefficient to q.24, rounded half away from zero
    function automatic longint qn(longint n);
        longint bias;
        bias = (n < 0) ? -64'sd976562 : 64'sd976562;
        return (n * 64'sd32768 + bias) / 64'sd1953125;
    endfunction

    localparam longint COEF_ROM [0:2][0:15] = '{
        '{qn(64'sd1000000000), qn(64'sd242591985), qn(-64'sd5659767100),
          qn(64'sd125462069938), qn(-64'sd791088106337), qn(64'sd2320032495246),
          qn(-64'sd3916607340150), qn(64'sd4029447497350), qn(-64'sd2493546793079),
          qn(64'sd847209859791), qn(-64'sd121830895978),
          64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
        '{qn(64'sd0), qn(-64'sd14792249), qn(-64'sd128305207), qn(-64'sd510569507),
          qn(64'sd227251464), qn(64'sd1708273026), qn(-64'sd2564631204),
          qn(64'sd1029697645), qn(64'sd128780795), qn(-64'sd135688620), qn(64'sd0),
          64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0},
        '{qn(64'sd10367640), qn(-64'sd15011793), qn(64'sd402817522),
          qn(-64'sd6267727260), qn(64'sd38913658454), qn(-64'sd147138160991),
          qn(64'sd309698004401), qn(-64'sd370982120960), qn(64'sd236624583559),
          qn(-64'sd64172341186), qn(64'sd0),
          64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0}
    };

    function automatic logic signed [COEF_W-1:0] coef_at(logic [CMD_W-1:0] sel,
                                                        logic [3:0] idx);
        logic signed [COEF_W-1:0] c;
        case (sel)
            CMD_CENTRAL: c = COEF_W'(COEF_ROM[0][idx]);
            CMD_TENSOR:  c = COEF_W'(COEF_ROM[1][idx]);
            CMD_SPINISO: c = COEF_W'(COEF_ROM[2][idx]);
            default:     c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/pgf_poly.sv =====
// pipelined horner evaluation of the fitted polynomial, one coefficient per stage
module pgf_poly #(
    parameter int COEFF_COUNT = pgf_pkg::COEFF_COUNT_DEF
) (
    input  logic                          clk,
    input  logic [pgf_pkg::RADIUS_W-1:0]  radius,
    input  logic [pgf_pkg::CMD_W-1:0]     command,
    output pgf_pkg::pgf_poly_t            poly
);

    localparam logic signed [pgf_pkg::ACC_W:0] HUGE_POS = 61'sh800000000000000;

    logic [pgf_pkg::RADIUS_W-1:0] r_reg   [0:COEFF_COUNT-1];
    logic [pgf_pkg::CMD_W-1:0]    sel_reg [0:COEFF_COUNT-1];
    pgf_pkg::pgf_poly_t           st_reg  [0:COEFF_COUNT-1];

    for (genvar j = 0; j < COEFF_COUNT; j++) begin : g_step
        logic [pgf_pkg::RADIUS_W-1:0]  r_in;
        logic [pgf_pkg::CMD_W-1:0]     sel_in;
        pgf_pkg::pgf_poly_t            st_in;
        pgf_pkg::pgf_poly_t            st_next;
        logic                          neg;
        logic [pgf_pkg::ACC_W-1:0]     mag_full;
        logic [pgf_pkg::MAG_W+pgf_pkg::RADIUS_W-1:0] prod;
        logic [62:0]                   p;
        logic signed [pgf_pkg::ACC_W:0] p_sig;
        logic signed [pgf_pkg::ACC_W:0] sum;

        if (j == 0) begin : g_first
            assign r_in   = radius;
            assign sel_in = command;
            assign st_in  = '0;
        end else begin : g_rest
            assign r_in   = r_reg[j-1];
            assign sel_in = sel_reg[j-1];
            assign st_in  = st_reg[j-1];
        end

        always_comb
        begin
            neg      = st_in.acc[pgf_pkg::ACC_W-1];
            mag_full = neg ? pgf_pkg::ACC_W'(-st_in.acc) : pgf_pkg::ACC_W'(st_in.acc);
            prod     = (pgf_pkg::MAG_W+pgf_pkg::RADIUS_W)'(mag_full[pgf_pkg::MAG_W-1:0])
                     * (pgf_pkg::MAG_W+pgf_pkg::RADIUS_W)'(r_in);
            p        = prod[74:12];
            p_sig    = neg ? -$signed({2'b00, p[58:0]}) : $signed({2'b00, p[58:0]});
            sum      = p_sig + (pgf_pkg::ACC_W+1)'(pgf_pkg::coef_at(sel_in,
                                   4'(COEFF_COUNT - 1 - j)));
            st_next.acc      = sum[pgf_pkg::ACC_W-1:0];
            st_next.huge     = st_in.huge;
            st_next.huge_neg = st_in.huge_neg;
            if (!st_in.huge) begin
                if (|p[62:59]) begin
                    st_next.huge     = 1'b1;
                    st_next.huge_neg = neg;
                end else if (sum >= HUGE_POS) begin
                    st_next.huge     = 1'b1;
                    st_next.huge_neg = 1'b0;
                end else if (sum <= -HUGE_POS) begin
                    st_next.huge     = 1'b1;
                    st_next.huge_neg = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[j]   <= r_in;
            sel_reg[j] <= sel_in;
            st_reg[j]  <= st_next;
        end
    end

    assign poly = st_reg[COEFF_COUNT-1];

endmodule

// ===== rtl/pgf_gauss.sv =====
// pipelined exp(-a*r*r): range reduction by ln2, taylor series, final shift
module pgf_gauss (
    input  logic                          clk,
    input  logic [pgf_pkg::RADIUS_W-1:0]  radius,
    input  logic [pgf_pkg::EXP_W-1:0]     exponent,
    output logic [pgf_pkg::E_W-1:0]       gauss
);

    localparam int TS = 2 * pgf_pkg::TAYLOR_TERMS;

    // range reduction
    logic [31:0]                  r2_reg;
    logic [pgf_pkg::EXP_W-1:0]    a_reg;
    logic [43:0]                  x_reg;
    logic [37:0]                  x3_reg;
    logic [5:0]                   kq_reg;
    logic                         uf3_reg;
    logic [32:0]                  z0_reg;
    logic [5:0]                   kq4_reg;
    logic                         uf4_reg;
    logic [31:0]                  z5_reg;
    logic [5:0]                   k5_reg;
    logic                         uf5_reg;
    logic [51:0]                  ax;
    logic [44:0]                  kprod;
    logic [37:0]                  klog;

    // taylor stages
    logic [31:0]                  z_reg  [0:TS-1];
    logic [5:0]                   k_reg  [0:TS-1];
    logic                         uf_reg [0:TS-1];
    logic [32:0]                  t_reg  [0:TS-1];
    logic [31:0]                  zt_reg [0:TS-1];
    logic [pgf_pkg::E_W-1:0]      gauss_reg;

    always_comb
    begin
        ax    = 52'(a_reg) * 52'(r2_reg);
        kprod = 45'(x_reg[43:26]) * 45'(pgf_pkg::K_RECIP);
        klog  = 38'(kq_reg) * 38'(pgf_pkg::LN2_Q32);
    end

    always_ff @(posedge clk)
    begin
        r2_reg  <= 32'(radius) * 32'(radius);
        a_reg   <= exponent;
        x_reg   <= ax[51:8];
        uf3_reg <= (64'(x_reg) >= pgf_pkg::UF_LIMIT);
        kq_reg  <= kprod[37:32];
        x3_reg  <= x_reg[37:0];
        z0_reg  <= 33'(x3_reg - klog);
        kq4_reg <= kq_reg;
        uf4_reg <= uf3_reg;
        if (64'(z0_reg) >= pgf_pkg::LN2_Q32) begin
            z5_reg <= 32'(64'(z0_reg) - pgf_pkg::LN2_Q32);
            k5_reg <= kq4_reg + 6'd1;
        end else begin
            z5_reg <= z0_reg[31:0];
            k5_reg <= kq4_reg;
        end
        uf5_reg <= uf4_reg;
    end

    for (genvar s = 0; s < TS; s++) begin : g_term
        localparam int N = pgf_pkg::TAYLOR_TERMS - s / 2;
        logic [31:0] z_in;
        logic [5:0]  k_in;
        logic        uf_in;
        logic [32:0] t_in;

        if (s == 0) begin : g_first
            assign z_in  = z5_reg;
            assign k_in  = k5_reg;
            assign uf_in = uf5_reg;
            assign t_in  = 33'(pgf_pkg::ONE_Q32);
        end else begin : g_rest
            assign z_in  = z_reg[s-1];
            assign k_in  = k_reg[s-1];
            assign uf_in = uf_reg[s-1];
            assign t_in  = t_reg[s-1];
        end

        if (s % 2 == 0) begin : g_mul
            logic [64:0] zt_prod;
            assign zt_prod = 65'(z_in) * 65'(t_in);
            always_ff @(posedge clk)
            begin
                zt_reg[s] <= zt_prod[63:32];
                t_reg[s]  <= t_in;
            end
        end else begin : g_sub
            logic [63:0] rc_prod;
            logic [31:0] term;
            assign rc_prod = 64'(zt_reg[s-1]) * 64'(pgf_pkg::RECIP[N]);
            assign term    = (N == 1) ? zt_reg[s-1] : rc_prod[63:32];
            always_ff @(posedge clk)
            begin
                zt_reg[s] <= zt_reg[s-1];
                t_reg[s]  <= 33'(pgf_pkg::ONE_Q32) - 33'(term);
            end
        end

        always_ff @(posedge clk)
        begin
            z_reg[s]  <= z_in;
            k_reg[s]  <= k_in;
            uf_reg[s] <= uf_in;
        end
    end

    always_ff @(posedge clk)
    begin
        gauss_reg <= uf_reg[TS-1] ? '0 : (t_reg[TS-1] >> k_reg[TS-1]);
    end

    assign gauss = gauss_reg;

endmodule

// ===== rtl/poly_gauss_fit_evaluator.sv =====
// top level: fitted polynomial times gaussian evaluator with exponent registers
//
//  channel   signals                                  direction
//  request   start, busy, request                     in
//  result    result_valid, result                     out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
//  one request per cycle; busy stays low
//  the pipeline depth is set by the exp unit's taylor stages
//  reset clears valid bits and loads the exponent registers with defaults
//  results are never held off; each appears for one cycle with result_valid
module poly_gauss_fit_evaluator #(
    parameter int COEFF_COUNT   = pgf_pkg::COEFF_COUNT_DEF,
    parameter int FRAC_BITS_OUT = pgf_pkg::FRAC_BITS_OUT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pgf_pkg::pgf_request_t          request,
    output logic                           result_valid,
    output pgf_pkg::pgf_result_t           result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pgf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pgf_pkg::EXP_W-1:0]      cfg_data
);

    localparam int GL       = pgf_pkg::GAUSS_LAT;
    localparam int DLY      = GL - COEFF_COUNT;
    localparam int SHIFT    = 56 - FRAC_BITS_OUT;
    localparam int PIPE_LAT = GL + 4;
    localparam int PROD_W   = 92;

    logic [pgf_pkg::EXP_W-1:0]    central_exp_reg;
    logic [pgf_pkg::EXP_W-1:0]    tensor_exp_reg;
    logic [pgf_pkg::EXP_W-1:0]    spiniso_exp_reg;

    logic                         in_vld_reg;
    logic [pgf_pkg::RADIUS_W-1:0] in_r_reg;
    logic [pgf_pkg::CMD_W-1:0]    in_sel_reg;
    logic [pgf_pkg::EXP_W-1:0]    in_a_reg;
    logic [pgf_pkg::EXP_W-1:0]    a_next;

    logic                         vld_reg [0:GL-1];
    logic [pgf_pkg::CMD_W-1:0]    sel_reg [0:GL-1];
    pgf_pkg::pgf_poly_t           pd_reg  [0:DLY-1];
    pgf_pkg::pgf_poly_t           poly_out;
    pgf_pkg::pgf_poly_t           poly_al;
    logic [pgf_pkg::E_W-1:0]      gauss_out;

    logic                         c1_vld_reg;
    logic                         c1_neg_reg;
    logic                         c1_zero_reg;
    logic                         c1_force_reg;
    logic [59:0]                  c1_hi_reg;
    logic [64:0]                  c1_lo_reg;
    logic                         c2_vld_reg;
    logic                         c2_neg_reg;
    logic                         c2_zero_reg;
    logic                         c2_force_reg;
    logic [PROD_W-1:0]            c2_sum_reg;

    logic                         pneg;
    logic [pgf_pkg::ACC_W-1:0]    mag_full;
    logic [PROD_W-1:0]            res;
    logic                         over;
    logic                         sat;
    logic [pgf_pkg::VALUE_W-1:0]  res24;
    pgf_pkg::pgf_result_t         result_next;
    pgf_pkg::pgf_result_t         result_reg;
    logic                         result_valid_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            central_exp_reg <= pgf_pkg::CENTRAL_EXP_RST;
            tensor_exp_reg  <= pgf_pkg::TENSOR_EXP_RST;
            spiniso_exp_reg <= pgf_pkg::SPINISO_EXP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pgf_pkg::CFG_CENTRAL: central_exp_reg <= cfg_data;
                pgf_pkg::CFG_TENSOR:  tensor_exp_reg  <= cfg_data;
                pgf_pkg::CFG_SPINISO: spiniso_exp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (request.command)
            pgf_pkg::CMD_CENTRAL: a_next = central_exp_reg;
            pgf_pkg::CMD_TENSOR:  a_next = tensor_exp_reg;
            default:              a_next = spiniso_exp_reg;
        endcase
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg       <= 1'b0;
            c1_vld_reg       <= 1'b0;
            c2_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < GL; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            in_vld_reg <= start && !busy;
            vld_reg[0] <= in_vld_reg;
            for (int i = 1; i < GL; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            c1_vld_reg       <= vld_reg[GL-1];
            c2_vld_reg       <= c1_vld_reg;
            result_valid_reg <= c2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_r_reg   <= request.radius;
        in_sel_reg <= request.command;
        in_a_reg   <= a_next;
        sel_reg[0] <= in_sel_reg;
        for (int i = 1; i < GL; i++) begin
            sel_reg[i] <= sel_reg[i-1];
        end
        pd_reg[0] <= poly_out;
        for (int i = 1; i < DLY; i++) begin
            pd_reg[i] <= pd_reg[i-1];
        end
    end

    pgf_poly #(
        .COEFF_COUNT(COEFF_COUNT)
    ) u_poly (
        .clk     (clk),
        .radius  (in_r_reg),
        .command (in_sel_reg),
        .poly    (poly_out)
    );

    pgf_gauss u_gauss (
        .clk      (clk),
        .radius   (in_r_reg),
        .exponent (in_a_reg),
        .gauss    (gauss_out)
    );

    assign poly_al = pd_reg[DLY-1];

    // magnitude times exponential, split into two partial products
    always_comb
    begin
        pneg     = poly_al.huge ? poly_al.huge_neg : poly_al.acc[pgf_pkg::ACC_W-1];
        mag_full = poly_al.acc[pgf_pkg::ACC_W-1] ? pgf_pkg::ACC_W'(-poly_al.acc)
                                                 : pgf_pkg::ACC_W'(poly_al.acc);
    end

    always_ff @(posedge clk)
    begin
        c1_neg_reg   <= pneg ^ (sel_reg[GL-1] == pgf_pkg::CMD_CENTRAL);
        c1_zero_reg  <= !(sel_reg[GL-1] inside {pgf_pkg::CMD_CENTRAL, pgf_pkg::CMD_TENSOR,
                                                pgf_pkg::CMD_SPINISO})
                        || (gauss_out == '0);
        c1_force_reg <= poly_al.huge;
        c1_hi_reg    <= 60'(mag_full[58:32]) * 60'(gauss_out);
        c1_lo_reg    <= 65'(mag_full[31:0]) * 65'(gauss_out);
        c2_neg_reg   <= c1_neg_reg;
        c2_zero_reg  <= c1_zero_reg;
        c2_force_reg <= c1_force_reg;
        c2_sum_reg   <= {c1_hi_reg, 32'd0} + PROD_W'(c1_lo_reg);
    end

    always_comb
    begin
        res   = c2_sum_reg >> SHIFT;
        over  = c2_neg_reg ? (res > PROD_W'(24'h800000)) : (res > PROD_W'(24'h7FFFFF));
        sat   = c2_force_reg || over;
        res24 = res[pgf_pkg::VALUE_W-1:0];
        if (c2_zero_reg) begin
            result_next.value     = '0;
            result_next.saturated = 1'b0;
        end else if (sat) begin
            result_next.value     = c2_neg_reg ? 24'sh800000 : 24'sh7FFFFF;
            result_next.saturated = 1'b1;
        end else begin
            result_next.value     = c2_neg_reg ? $signed(-res24) : $signed(res24);
            result_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, PIPE_LAT))
        else $error("result without a request");

    a_sat_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.value == 24'sh7FFFFF || result.value == 24'sh800000))
        else $error("saturated value not at a range end");

    a_gauss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[GL-1] && gauss_out[pgf_pkg::E_W-1] |-> gauss_out[pgf_pkg::E_W-2:0] == '0)
        else $error("exponential above one");

endmodule
